// ----- hw/rtl/elliptical_vignette_pixel_unit_assert.svh -----
// Assertion macros used by the checker of the vignette pixel unit.
`ifndef ELLIPTICAL_VIGNETTE_PIXEL_UNIT_ASSERT_SVH
`define ELLIPTICAL_VIGNETTE_PIXEL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define VIG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define VIG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/vig_pkg.sv -----
// Shared widths, constants and register codes of the vignette pixel unit.
package vig_pkg;

  localparam int ROW_W     = 12;
  localparam int CH_W      = 8;
  localparam int DIM_W     = 13;
  localparam int INV_W     = 33;
  localparam int FALL_W    = 41;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 41;

  // Largest image dimension honoured for the centre; larger values are clamped.
  localparam int MAX_DIM       = 4096;
  localparam int GAIN_BITS_DEF = 16;

  // Offset magnitude, its square, and one axis term of the distance.
  localparam int MAG_W  = 13;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int AXIS_W = SQ_W + INV_W;
  localparam int DIST_W = AXIS_W + 1;

  // Pipeline: 11 stages, the last one is the output register.
  localparam int NUM_STAGES = 11;

  localparam logic [DIM_W-1:0] ROWS_RESET = 13'd480;
  localparam logic [DIM_W-1:0] COLS_RESET = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS    = 3'd0,
    CFG_COLS    = 3'd1,
    CFG_INV_H   = 3'd2,
    CFG_INV_W   = 3'd3,
    CFG_FALLOFF = 3'd4
  } cfg_idx_t;

endpackage

// ----- hw/rtl/vig_pix_in_if.sv -----
// Input pixel channel: valid, ready and one pixel word with its coordinates.
interface vig_pix_in_if;
  import vig_pkg::*;

  logic            valid;
  logic            ready;
  logic [ROW_W-1:0] row_index;
  logic [ROW_W-1:0] col_index;
  logic [CH_W-1:0] channel_0;
  logic [CH_W-1:0] channel_1;
  logic [CH_W-1:0] channel_2;

  modport source (output valid, row_index, col_index, channel_0, channel_1, channel_2,
                  input ready);
  modport sink   (input valid, row_index, col_index, channel_0, channel_1, channel_2,
                  output ready);
endinterface

// ----- hw/rtl/vig_pix_out_if.sv -----
// Output pixel channel: valid, ready and one word of scaled channels.
interface vig_pix_out_if;
  import vig_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] scaled_0;
  logic [CH_W-1:0] scaled_1;
  logic [CH_W-1:0] scaled_2;

  modport source (output valid, scaled_0, scaled_1, scaled_2, input ready);
  modport sink   (input valid, scaled_0, scaled_1, scaled_2, output ready);
endinterface

// ----- hw/rtl/vig_axis_lane.sv -----
// One axis lane: squared doubled offset from the centre times its reciprocal.
module vig_axis_lane (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [vig_pkg::ROW_W-1:0]   pos,
  input  logic [vig_pkg::DIM_W-1:0]   dim,
  input  logic [vig_pkg::INV_W-1:0]   inv,
  output logic [vig_pkg::AXIS_W-1:0]  term
);
  import vig_pkg::*;

  localparam int LO_W = 17;
  localparam int HI_W = INV_W - LO_W;

  logic [DIM_W-1:0]       dim_c;
  logic [MAG_W-1:0]       twice;
  logic [MAG_W-1:0]       mag_next;
  logic [MAG_W-1:0]       mag;
  logic [SQ_W-1:0]        sq;
  logic [SQ_W+LO_W-1:0]   pp_lo;
  logic [SQ_W+HI_W-1:0]   pp_hi;

  always_comb begin
    dim_c = (32'(dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim;
    twice = {pos, 1'b0};
    mag_next = (twice >= dim_c) ? (twice - dim_c) : (dim_c - twice);
  end

  // Square, then split the reciprocal in two so each product stays narrow.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag <= mag_next;
    end
    if (en[1]) begin
      sq <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (en[2]) begin
      pp_lo <= (SQ_W+LO_W)'(sq) * (SQ_W+LO_W)'(inv[LO_W-1:0]);
      pp_hi <= (SQ_W+HI_W)'(sq) * (SQ_W+HI_W)'(inv[INV_W-1:LO_W]);
    end
    if (en[3]) begin
      term <= AXIS_W'(pp_lo) + (AXIS_W'(pp_hi) << LO_W);
    end
  end
endmodule

// ----- hw/rtl/vig_gain_unit.sv -----
// Merges the two axis terms into the distance and turns it into a gain.
module vig_gain_unit #(
  parameter int GAIN_BITS = vig_pkg::GAIN_BITS_DEF
) (
  input  logic                        clk,
  input  logic [5:0]                  en,
  input  logic [vig_pkg::AXIS_W-1:0]  term_row,
  input  logic [vig_pkg::AXIS_W-1:0]  term_col,
  input  logic [vig_pkg::FALL_W-1:0]  inv_falloff,
  output logic [GAIN_BITS:0]          gain
);
  import vig_pkg::*;

  localparam int EC_W   = 15;                 // excess chunk
  localparam int NCHUNK = DIST_W / EC_W;
  localparam int FL_W   = 21;                 // low falloff part
  localparam int FH_W   = FALL_W - FL_W;
  localparam int C_W    = EC_W + FALL_W;
  localparam int S_W    = C_W + EC_W;
  localparam int P_W    = DIST_W + FALL_W;
  localparam int SAT_B  = 56;                 // loss reaches one at 2^56
  localparam logic [DIST_W-1:0] UNIT = DIST_W'(64'h1_0000_0000);
  localparam logic [GAIN_BITS:0] ONE = {1'b1, {GAIN_BITS{1'b0}}};

  logic [DIST_W-1:0]      dist_sum;
  logic [DIST_W-1:0]      excess;
  logic                   pass_c;
  logic [3:0]             pass;
  logic [EC_W+FL_W-1:0]   pl [NCHUNK];
  logic [EC_W+FH_W-1:0]   ph [NCHUNK];
  logic [C_W-1:0]         cs [NCHUNK];
  logic [S_W-1:0]         s01;
  logic [S_W-1:0]         s23;
  logic [P_W-1:0]         prod;
  logic                   over;
  logic [GAIN_BITS-1:0]   loss;

  assign pass_c = (dist_sum <= UNIT) || (inv_falloff == '0);

  always_comb begin
    prod = P_W'(s01) + (P_W'(s23) << (2 * EC_W));
    over = |prod[P_W-1:SAT_B];
    loss = prod[SAT_B-1:SAT_B-GAIN_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dist_sum <= DIST_W'(term_row) + DIST_W'(term_col);
    end
    if (en[1]) begin
      excess  <= dist_sum - UNIT;
      pass[0] <= pass_c;
    end
    if (en[2]) begin
      for (int i = 0; i < NCHUNK; i++) begin
        pl[i] <= (EC_W+FL_W)'(excess[EC_W*i +: EC_W]) * (EC_W+FL_W)'(inv_falloff[FL_W-1:0]);
        ph[i] <= (EC_W+FH_W)'(excess[EC_W*i +: EC_W]) *
                 (EC_W+FH_W)'(inv_falloff[FALL_W-1:FL_W]);
      end
      pass[1] <= pass[0];
    end
    if (en[3]) begin
      for (int i = 0; i < NCHUNK; i++) begin
        cs[i] <= C_W'(pl[i]) + (C_W'(ph[i]) << FL_W);
      end
      pass[2] <= pass[1];
    end
    if (en[4]) begin
      s01     <= S_W'(cs[0]) + (S_W'(cs[1]) << EC_W);
      s23     <= S_W'(cs[2]) + (S_W'(cs[3]) << EC_W);
      pass[3] <= pass[2];
    end
    if (en[5]) begin
      if (pass[3]) begin
        gain <= ONE;
      end else if (over) begin
        gain <= '0;
      end else begin
        gain <= ONE - (GAIN_BITS+1)'(loss);
      end
    end
  end
endmodule

// ----- hw/rtl/vig_chan_lane.sv -----
// One colour lane: delays its byte alongside the gain path and scales it.
module vig_chan_lane #(
  parameter int GAIN_BITS = vig_pkg::GAIN_BITS_DEF
) (
  input  logic                            clk,
  input  logic [vig_pkg::NUM_STAGES-1:0]  en,
  input  logic [vig_pkg::CH_W-1:0]        ch,
  input  logic [GAIN_BITS:0]              gain,
  output logic [vig_pkg::CH_W-1:0]        scaled
);
  import vig_pkg::*;

  localparam int DLY  = NUM_STAGES - 1;
  localparam int PR_W = CH_W + GAIN_BITS + 1;

  logic [CH_W-1:0] dly [DLY];
  logic [PR_W-1:0] prod;

  assign prod = PR_W'(dly[DLY-1]) * PR_W'(gain);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dly[0] <= ch;
    end
    for (int k = 1; k < DLY; k++) begin
      if (en[k]) begin
        dly[k] <= dly[k-1];
      end
    end
    if (en[DLY]) begin
      scaled <= prod[GAIN_BITS+CH_W-1:GAIN_BITS];
    end
  end
endmodule

// ----- hw/rtl/elliptical_vignette_pixel_unit.sv -----
// Elliptical linear vignette unit: scales each pixel by a distance-based gain.
// Each accepted input word yields one output word; one word per cycle while the output is taken.
// The rate is set by the 11-stage pipeline, which takes a new word every cycle unless it is full and stalled.
// Stalls collapse bubbles stage by stage; input is taken while a result waits if a stage is free.
// Synchronous reset empties the pipeline and restores the register defaults.
module elliptical_vignette_pixel_unit #(
  parameter int GAIN_BITS = vig_pkg::GAIN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  vig_pix_in_if.sink                     pix_in,
  vig_pix_out_if.source                  pix_out,
  input  logic                           cfg_we,
  input  logic [vig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vig_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import vig_pkg::*;

  // Configuration registers. The user must see that they are only written while the
  // pipeline is empty, so every stage may read them directly; the block does not enforce it.
  logic [DIM_W-1:0]  image_rows;
  logic [DIM_W-1:0]  image_cols;
  logic [INV_W-1:0]  inv_height_sq;
  logic [INV_W-1:0]  inv_width_sq;
  logic [FALL_W-1:0] inv_falloff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows    <= ROWS_RESET;
      image_cols    <= COLS_RESET;
      inv_height_sq <= '0;
      inv_width_sq  <= '0;
      inv_falloff   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:    image_rows    <= cfg_data[DIM_W-1:0];
        CFG_COLS:    image_cols    <= cfg_data[DIM_W-1:0];
        CFG_INV_H:   inv_height_sq <= cfg_data[INV_W-1:0];
        CFG_INV_W:   inv_width_sq  <= cfg_data[INV_W-1:0];
        CFG_FALLOFF: inv_falloff   <= cfg_data[FALL_W-1:0];
        default: ;   // Unused indexes are ignored.
      endcase
    end
  end

  // Pipeline control. Each stage has a valid bit; a stage may load when it
  // is empty or when the stage below it can move. Because a stage moves
  // exactly when the output is taken or some stage at or below it is empty,
  // the enable of each stage is worked out independently of the others.
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] en;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = pix_out.ready || !(&valid[NUM_STAGES-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= pix_in.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign pix_in.ready  = en[0];
  assign pix_out.valid = valid[NUM_STAGES-1];

  // Two axis lanes side by side: rows against the height reciprocal and
  // columns against the width reciprocal (stages 0 to 3).
  logic [AXIS_W-1:0] term_row;
  logic [AXIS_W-1:0] term_col;

  vig_axis_lane u_row_lane (
    .clk  (clk),
    .en   (en[3:0]),
    .pos  (pix_in.row_index),
    .dim  (image_rows),
    .inv  (inv_height_sq),
    .term (term_row)
  );

  vig_axis_lane u_col_lane (
    .clk  (clk),
    .en   (en[3:0]),
    .pos  (pix_in.col_index),
    .dim  (image_cols),
    .inv  (inv_width_sq),
    .term (term_col)
  );

  // The merge adds the two lane terms into the distance (stage 4), then the falloff
  // product is built from the excess and partial products over stages 5 to 9.
  logic [GAIN_BITS:0] gain;

  vig_gain_unit #(
    .GAIN_BITS (GAIN_BITS)
  ) u_gain (
    .clk         (clk),
    .en          (en[9:4]),
    .term_row    (term_row),
    .term_col    (term_col),
    .inv_falloff (inv_falloff),
    .gain        (gain)
  );

  // Three colour lanes apply the common gain in the output stage.
  vig_chan_lane #(
    .GAIN_BITS (GAIN_BITS)
  ) u_chan_0 (
    .clk    (clk),
    .en     (en),
    .ch     (pix_in.channel_0),
    .gain   (gain),
    .scaled (pix_out.scaled_0)
  );

  vig_chan_lane #(
    .GAIN_BITS (GAIN_BITS)
  ) u_chan_1 (
    .clk    (clk),
    .en     (en),
    .ch     (pix_in.channel_1),
    .gain   (gain),
    .scaled (pix_out.scaled_1)
  );

  vig_chan_lane #(
    .GAIN_BITS (GAIN_BITS)
  ) u_chan_2 (
    .clk    (clk),
    .en     (en),
    .ch     (pix_in.channel_2),
    .gain   (gain),
    .scaled (pix_out.scaled_2)
  );
endmodule

// ----- hw/rtl/vig_checker.sv -----
// Port-level checker of the vignette pixel unit and its bind.
`include "elliptical_vignette_pixel_unit_assert.svh"

module vig_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vig_pkg::CH_W-1:0]   scaled_0,
  input logic [vig_pkg::CH_W-1:0]   scaled_1,
  input logic [vig_pkg::CH_W-1:0]   scaled_2
);
  import vig_pkg::*;

  // A stalled output word stays put.
  `VIG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(scaled_0) && $stable(scaled_1) && $stable(scaled_2), "stalled output word changed")

  // Reset leaves no word in flight.
  `VIG_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid, "output valid straight after reset")

  // With the output free to move, the whole pipeline moves and takes input.
  `VIG_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready, "input stalled while the output can move")
endmodule

bind elliptical_vignette_pixel_unit vig_checker u_vig_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .scaled_0  (pix_out.scaled_0),
  .scaled_1  (pix_out.scaled_1),
  .scaled_2  (pix_out.scaled_2)
);

// ----- sim/elliptical_vignette_pixel_unit_test.sv -----
// Self-checking testbench for the elliptical vignette pixel unit.
module elliptical_vignette_pixel_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vig_pkg::*;

  // Gain arithmetic of the default build: Q1.16 gain, Q.32 distance, Q17.24 falloff.
  localparam int GAIN_FRAC = GAIN_BITS_DEF;
  localparam int LOSS_SHIFT = 56 - GAIN_FRAC;
  localparam logic [63:0] UNIT_DIST = 64'd1 << 32;
  localparam logic [GAIN_FRAC:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

  // An index that names no register; writes to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 3'd6;

  localparam logic [INV_W-1:0] INV_MAX = '1;
  localparam logic [FALL_W-1:0] FALLOFF_MAX = '1;
  localparam logic [FALL_W-1:0] FALLOFF_UNITY = 41'd1 << 24;

  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [ROW_W-1:0] col_index;
    rgb_t             channel;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  vig_pix_in_if  pix_in();
  vig_pix_out_if pix_out();

  elliptical_vignette_pixel_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .pix_out   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the register file, updated as each write is issued.
  logic [DIM_W-1:0]  rows_reg;
  logic [DIM_W-1:0]  cols_reg;
  logic [INV_W-1:0]  inv_h_reg;
  logic [INV_W-1:0]  inv_w_reg;
  logic [FALL_W-1:0] falloff_reg;

  // Scaled pixels still owed by the block, oldest first.
  rgb_t pending_shades[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Square of the doubled offset 2*pos - extent, with the extent clamped to the
  // largest supported image size. The magnitude never exceeds 8190, so the
  // square fits the block's squared-offset width.
  function automatic logic [SQ_W-1:0] offset_square(logic [ROW_W-1:0] pos,
                                                    logic [DIM_W-1:0] extent);
    logic [DIM_W:0] span;
    logic [DIM_W:0] twice;
    logic [DIM_W:0] mag;
    span  = (extent > MAX_DIM) ? (DIM_W+1)'(MAX_DIM) : {1'b0, extent};
    twice = {1'b0, pos, 1'b0};
    mag   = (twice >= span) ? twice - span : span - twice;
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  // Gain for a distance in Q.32. The loss is formed at full precision, so a
  // product beyond 64 bits simply shows up as a loss far above one.
  function automatic logic [GAIN_FRAC:0] gain_at(logic [63:0] dist_q32);
    logic [127:0] loss;
    if (dist_q32 <= UNIT_DIST || falloff_reg == '0) return GAIN_ONE;
    loss = (128'(dist_q32 - UNIT_DIST) * 128'(falloff_reg)) >> LOSS_SHIFT;
    if (loss >= 128'(GAIN_ONE)) return '0;
    return GAIN_ONE - loss[GAIN_FRAC:0];
  endfunction

  // Expected scaled word for one pixel under the current register settings.
  function automatic rgb_t vignette_of(pixel_t px);
    logic [63:0] dist_q32;
    logic [GAIN_FRAC:0] gain;
    logic [CH_W+GAIN_FRAC:0] prod;
    rgb_t shade;
    dist_q32 = 64'(offset_square(px.row_index, rows_reg)) * 64'(inv_h_reg)
             + 64'(offset_square(px.col_index, cols_reg)) * 64'(inv_w_reg);
    gain = gain_at(dist_q32);
    for (int k = 0; k < 3; k++) begin
      prod = px.channel[k] * gain;
      shade[k] = prod[GAIN_FRAC +: CH_W];
    end
    return shade;
  endfunction

  // Rounded 2^32 / extent^2, the reciprocal software would load for an ellipse.
  function automatic logic [INV_W-1:0] inverse_square(int unsigned extent);
    logic [63:0] sq;
    sq = 64'(extent) * 64'(extent);
    return INV_W'(((64'd1 << 33) / sq + 64'd1) >> 1);
  endfunction

  function automatic pixel_t pixel_at(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                      rgb_t ch);
    pixel_t px;
    px.row_index = row;
    px.col_index = col;
    px.channel = ch;
    return px;
  endfunction

  // Mostly coordinates inside the image; now and then anything the field holds.
  function automatic logic [ROW_W-1:0] random_coord(logic [DIM_W-1:0] extent);
    int unsigned top;
    top = (extent > MAX_DIM) ? MAX_DIM : extent;
    if (top == 0 || $urandom_range(0, 4) == 0) return ROW_W'($urandom);
    return ROW_W'($urandom_range(0, top - 1));
  endfunction

  function automatic pixel_t random_pixel();
    return pixel_at(random_coord(rows_reg), random_coord(cols_reg), 24'($urandom));
  endfunction

  // Mostly short gaps, with the odd long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge and is sampled on the rising one.
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      CFG_ROWS:    rows_reg = data[DIM_W-1:0];
      CFG_COLS:    cols_reg = data[DIM_W-1:0];
      CFG_INV_H:   inv_h_reg = data[INV_W-1:0];
      CFG_INV_W:   inv_w_reg = data[INV_W-1:0];
      CFG_FALLOFF: falloff_reg = data[FALL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all five registers. The bits above the width of the first four carry junk,
  // which the block must drop, and a stray write to an unused index is thrown in.
  task automatic load_setting(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                              logic [INV_W-1:0] inv_h, logic [INV_W-1:0] inv_w,
                              logic [FALL_W-1:0] falloff);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_ROWS, {junk[CFG_DAT_W-DIM_W-1:0], rows});
    write_reg(CFG_COLS, {junk[CFG_DAT_W-DIM_W+7:8], cols});
    write_reg(CFG_INV_H, {junk[CFG_DAT_W-INV_W-1:0], inv_h});
    write_reg(CFG_INV_W, {junk[CFG_DAT_W-INV_W+15:16], inv_w});
    write_reg(CFG_FALLOFF, falloff);
    write_reg(SPARE_INDEX, junk[CFG_DAT_W-1:0]);
  endtask

  // Holds valid low for a stretch given by n; nothing happens for n of zero.
  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one pixel word and records its expected result once it is taken.
  // Valid stays high afterwards unless a gap follows, so back-to-back words need no extra edge.
  task automatic send_pixel(pixel_t px);
    @(negedge clk);
    pix_in.valid <= 1'b1;
    pix_in.row_index <= px.row_index;
    pix_in.col_index <= px.col_index;
    pix_in.channel_0 <= px.channel[0];
    pix_in.channel_1 <= px.channel[1];
    pix_in.channel_2 <= px.channel[2];
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pending_shades.push_back(vignette_of(px));
    if (tx_gaps && $urandom_range(0, 2) == 0) pause_sender(gap_length());
  endtask

  // The sender stops and waits for every owed word; the block is then idle,
  // because each pixel yields exactly one result.
  task automatic wait_for_shades();
    pause_sender(1);
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  // Receiver: ready is lowered for a requested hold-off, for random stalls when
  // they are enabled, and otherwise stays high. At most one assignment per falling edge.
  initial begin : receiver
    int unsigned n;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        pix_out.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        n = gap_length();
        pix_out.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // Each output word taken is compared, channel by channel, with the oldest
  // expectation; a word with nothing waiting is an error in itself.
  always @(posedge clk) begin : shade_check
    rgb_t got;
    rgb_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = {pix_out.scaled_2, pix_out.scaled_1, pix_out.scaled_0};
      if (pending_shades.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_shades.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t scaled_%0d: expected %0d, actual %0d", $time, k, want[k], got[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: a run that outlives the limit has hung somewhere.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Register settings for the random phases
  // ---------------------------------------------------------------------------

  // Kind 0 is every register at its largest value, kind 1 the smallest image
  // with a unit ellipse, kind 2 zero dimensions with random reciprocals, and
  // anything else a plausible image, ellipse and falloff.
  task automatic choose_setting(int unsigned kind);
    int unsigned r;
    int unsigned c;
    int unsigned hh;
    int unsigned ww;
    logic [INV_W-1:0] ih;
    logic [INV_W-1:0] iw;
    logic [63:0] corner;
    logic [63:0] fall;
    case (kind)
      0: load_setting('1, '1, INV_MAX, INV_MAX, FALLOFF_MAX);
      1: load_setting(13'd1, 13'd1, inverse_square(1), inverse_square(1), FALLOFF_UNITY);
      2: load_setting('0, '0,
                      INV_W'({$urandom, $urandom}) >> $urandom_range(0, INV_W - 1),
                      INV_W'({$urandom, $urandom}) >> $urandom_range(0, INV_W - 1),
                      FALL_W'({$urandom, $urandom}) >> $urandom_range(0, FALL_W - 1));
      default: begin
        r = $urandom_range(1, MAX_DIM);
        c = $urandom_range(1, MAX_DIM);
        hh = $urandom_range((r / 2 > 0) ? r / 2 : 1, r + r / 2);
        ww = $urandom_range((c / 2 > 0) ? c / 2 : 1, c + c / 2);
        ih = inverse_square(hh);
        iw = inverse_square(ww);
        // Doubled offsets at a corner equal the image size itself.
        corner = 64'(r) * 64'(r) * 64'(ih) + 64'(c) * 64'(c) * 64'(iw);
        if (corner > UNIT_DIST && $urandom_range(0, 5) != 0) begin
          fall = (64'd1 << 56) / (corner - UNIT_DIST);
          if (fall > 64'(FALLOFF_MAX)) fall = 64'(FALLOFF_MAX);
        end else begin
          fall = 64'(FALL_W'({$urandom, $urandom}) >> $urandom_range(0, FALL_W - 1));
        end
        load_setting(DIM_W'(r), DIM_W'(c), ih, iw, FALL_W'(fall));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight after reset both reciprocals are zero, so every pixel, the
  // extremes of row, column and colour included, must pass through untouched.
  task automatic test_pass_through();
    send_pixel(pixel_at(12'd0, 12'd0, {8'd0, 8'd0, 8'd0}));
    send_pixel(pixel_at(12'd4095, 12'd4095, {8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_at(12'd240, 12'd320, {8'hAA, 8'h55, 8'hAA}));
    send_pixel(pixel_at(12'd4095, 12'd0, {8'h55, 8'hAA, 8'h55}));
    wait_for_shades();
  endtask

  // An ellipse that just fits a 480 by 640 image with unit falloff: the centre
  // and the edge keep full gain, the corners fade to nothing or nearly so, points between
  // are scaled down.
  task automatic test_ellipse_gain();
    load_setting(13'd480, 13'd640, inverse_square(480), inverse_square(640), FALLOFF_UNITY);
    send_pixel(pixel_at(12'd240, 12'd320, {8'd255, 8'd128, 8'd1}));
    send_pixel(pixel_at(12'd0, 12'd320, {8'd255, 8'd128, 8'd1}));
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_at(12'd479, 12'd639, {8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_at(12'd0, 12'd160, {8'd200, 8'd100, 8'd50}));
    send_pixel(pixel_at(12'd60, 12'd40, {8'd255, 8'd17, 8'd99}));
    wait_for_shades();
  endtask

  // With no falloff the region outside the ellipse keeps full gain as well.
  task automatic test_zero_falloff();
    load_setting(13'd480, 13'd640, inverse_square(480), inverse_square(640), '0);
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd128, 8'd7}));
    send_pixel(pixel_at(12'd479, 12'd639, {8'd1, 8'd2, 8'd3}));
    wait_for_shades();
  endtask

  // Loss of one or more, including a loss product beyond 64 bits, blanks the
  // pixel; a loss just above one half shows the truncation of the loss.
  task automatic test_large_loss();
    load_setting(13'd4096, 13'd4096, INV_MAX, INV_MAX, FALLOFF_MAX);
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_at(12'd2048, 12'd2048, {8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_at(12'd2048, 12'd2049, {8'd255, 8'd255, 8'd255}));
    wait_for_shades();
    // A doubled offset of two against a reciprocal of 2^31 lands exactly at
    // distance two, so unit falloff gives a loss of exactly one.
    load_setting(13'd2, 13'd2, INV_W'(64'd1 << 31), '0, FALLOFF_UNITY);
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd255, 8'd255}));
    wait_for_shades();
    load_setting(13'd2, 13'd2, INV_W'(64'd1 << 31), '0, (FALLOFF_UNITY >> 1) + 41'd1);
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd254, 8'd3}));
    wait_for_shades();
  endtask

  // Dimensions above the maximum are clamped, zero dimensions put the centre
  // at the origin, and coordinates beyond the image are used as they stand.
  task automatic test_dimension_edges();
    load_setting('1, 13'd4097, inverse_square(1024), inverse_square(2048), FALLOFF_UNITY >> 2);
    send_pixel(pixel_at(12'd2048, 12'd2048, {8'd255, 8'd128, 8'd64}));
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd128, 8'd64}));
    wait_for_shades();
    load_setting('0, '0, inverse_square(64), inverse_square(64), FALLOFF_UNITY);
    send_pixel(pixel_at(12'd0, 12'd0, {8'd255, 8'd128, 8'd64}));
    send_pixel(pixel_at(12'd40, 12'd10, {8'd255, 8'd128, 8'd64}));
    send_pixel(pixel_at(12'd4095, 12'd4095, {8'd255, 8'd128, 8'd64}));
    wait_for_shades();
  endtask

  // The receiver holds off for a long stretch while words keep coming back to
  // back, so the pipeline fills and must stall its input without losing or
  // repeating a word. The sender then waits until every result is in.
  task automatic test_backpressure();
    choose_setting(3);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (40) send_pixel(random_pixel());
    wait_for_shades();
  endtask

  // Random words under a fresh setting per phase. The phases cover every mix
  // of sender gaps and receiver stalls, including one with neither.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_shades();
      choose_setting(phase);
      tx_gaps = phase[0];
      rx_stalls = phase[1] | phase[2];
      repeat (WORDS_PER_PHASE) send_pixel(random_pixel());
    end
    wait_for_shades();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.row_index = '0;
    pix_in.col_index = '0;
    pix_in.channel_0 = '0;
    pix_in.channel_1 = '0;
    pix_in.channel_2 = '0;
    rows_reg = ROWS_RESET;
    cols_reg = COLS_RESET;
    inv_h_reg = '0;
    inv_w_reg = '0;
    falloff_reg = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pass_through();
    test_ellipse_gain();
    test_zero_falloff();
    test_large_loss();
    test_dimension_edges();
    test_backpressure();
    test_random_traffic();

    // Let the pipeline run dry with the receiver ready, so a stray extra word
    // would still be caught.
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    wait_for_shades();
    repeat (NUM_STAGES + 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
